// File: hw/rtl/fsc_pkg.sv
// Shared constants, types and the signature table of the file signature classifier.
// No dependencies; every other file of the block except fsc_in_if imports this package.
`default_nettype none

package fsc_pkg;

  // Default number of leading bytes kept per buffer
  localparam int unsigned DEF_HEADER_WINDOW = 12;

  // Span of the signature table: no row reaches past this byte
  localparam int unsigned SIG_SPAN  = 12;
  localparam int unsigned SIG_IDX_W = $clog2(SIG_SPAN);
  localparam int unsigned ROW_COUNT = 31;

  localparam int unsigned TYPE_W = 5;
  localparam int unsigned ROW_W  = 6;

  // File type codes
  localparam logic [TYPE_W-1:0] FT_DOS_EXE  = 5'd0;
  localparam logic [TYPE_W-1:0] FT_ELF      = 5'd1;
  localparam logic [TYPE_W-1:0] FT_RAR      = 5'd2;
  localparam logic [TYPE_W-1:0] FT_ZIP      = 5'd3;
  localparam logic [TYPE_W-1:0] FT_GZIP     = 5'd4;
  localparam logic [TYPE_W-1:0] FT_BZIP     = 5'd5;
  localparam logic [TYPE_W-1:0] FT_SZDD     = 5'd6;
  localparam logic [TYPE_W-1:0] FT_CAB      = 5'd7;
  localparam logic [TYPE_W-1:0] FT_CHM      = 5'd8;
  localparam logic [TYPE_W-1:0] FT_SIS      = 5'd9;
  localparam logic [TYPE_W-1:0] FT_SCRENC   = 5'd10;
  localparam logic [TYPE_W-1:0] FT_GRAPHICS = 5'd11;
  localparam logic [TYPE_W-1:0] FT_RIFF     = 5'd12;
  localparam logic [TYPE_W-1:0] FT_OLE2     = 5'd13;
  localparam logic [TYPE_W-1:0] FT_PDF      = 5'd14;
  localparam logic [TYPE_W-1:0] FT_CRYPTFF  = 5'd15;
  localparam logic [TYPE_W-1:0] FT_IGNORED  = 5'd16;
  localparam logic [TYPE_W-1:0] FT_UNKNOWN  = 5'd17;

  // Row reported when nothing matched
  localparam logic [ROW_W-1:0] NO_ROW = 6'd33;

  typedef logic [SIG_SPAN-1:0][7:0] sig_win_t;

  typedef struct packed {
    logic [3:0]              offset;
    logic [3:0]              length;
    logic [0:SIG_SPAN-1][7:0] bytes;
    logic [TYPE_W-1:0]       ftype;
  } sig_row_t;

  // Status of the capture stage towards the top level
  typedef struct packed {
    logic valid;
    logic last;
  } cap_stat_t;

  // Signatures in priority order; byte 0 of a row sits at its offset
  localparam sig_row_t SIG_TABLE [ROW_COUNT] = '{
    '{4'd0, 4'd2,  {8'h4D,8'h5A,8'h00,8'h00,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_DOS_EXE},
    '{4'd0, 4'd4,  {8'h7F,8'h45,8'h4C,8'h46,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_ELF},
    '{4'd0, 4'd4,  {8'h52,8'h61,8'h72,8'h21,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_RAR},
    '{4'd0, 4'd4,  {8'h50,8'h4B,8'h03,8'h04,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_ZIP},
    '{4'd0, 4'd8,  {8'h50,8'h4B,8'h30,8'h30,8'h50,8'h4B,
                    8'h03,8'h04,8'h00,8'h00,8'h00,8'h00}, FT_ZIP},
    '{4'd0, 4'd2,  {8'h1F,8'h8B,8'h00,8'h00,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_GZIP},
    '{4'd0, 4'd3,  {8'h42,8'h5A,8'h68,8'h00,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_BZIP},
    '{4'd0, 4'd4,  {8'h53,8'h5A,8'h44,8'h44,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_SZDD},
    '{4'd0, 4'd4,  {8'h4D,8'h53,8'h43,8'h46,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_CAB},
    '{4'd0, 4'd4,  {8'h49,8'h54,8'h53,8'h46,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_CHM},
    '{4'd8, 4'd4,  {8'h19,8'h04,8'h00,8'h10,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_SIS},
    '{4'd0, 4'd4,  {8'h23,8'h40,8'h7E,8'h5E,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_SCRENC},
    '{4'd0, 4'd3,  {8'h47,8'h49,8'h46,8'h00,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_GRAPHICS},
    '{4'd0, 4'd2,  {8'h42,8'h4D,8'h00,8'h00,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_GRAPHICS},
    '{4'd0, 4'd3,  {8'hFF,8'hD8,8'hFF,8'h00,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_GRAPHICS},
    '{4'd6, 4'd4,  {8'h4A,8'h46,8'h49,8'h46,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_GRAPHICS},
    '{4'd6, 4'd4,  {8'h45,8'h78,8'h69,8'h66,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_GRAPHICS},
    '{4'd0, 4'd4,  {8'h89,8'h50,8'h4E,8'h47,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_GRAPHICS},
    '{4'd0, 4'd4,  {8'h52,8'h49,8'h46,8'h46,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_RIFF},
    '{4'd0, 4'd4,  {8'h52,8'h49,8'h46,8'h58,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_RIFF},
    '{4'd0, 4'd8,  {8'hD0,8'hCF,8'h11,8'hE0,8'hA1,8'hB1,
                    8'h1A,8'hE1,8'h00,8'h00,8'h00,8'h00}, FT_OLE2},
    '{4'd0, 4'd5,  {8'h25,8'h50,8'h44,8'h46,8'h2D,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_PDF},
    '{4'd0, 4'd8,  {8'hB6,8'hB9,8'hAC,8'hAE,8'hFE,8'hFF,
                    8'hFF,8'hFF,8'h00,8'h00,8'h00,8'h00}, FT_CRYPTFF},
    '{4'd0, 4'd4,  {8'h00,8'h00,8'h01,8'hB3,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_IGNORED},
    '{4'd0, 4'd4,  {8'h00,8'h00,8'h01,8'hBA,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_IGNORED},
    '{4'd0, 4'd4,  {8'h4F,8'h67,8'h67,8'h53,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_IGNORED},
    '{4'd0, 4'd3,  {8'h49,8'h44,8'h33,8'h00,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_IGNORED},
    '{4'd0, 4'd3,  {8'hFF,8'hFB,8'h90,8'h00,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_IGNORED},
    '{4'd0, 4'd11, {8'h25,8'h21,8'h50,8'h53,8'h2D,8'h41,
                    8'h64,8'h6F,8'h62,8'h65,8'h2D,8'h00}, FT_IGNORED},
    '{4'd0, 4'd7,  {8'h30,8'h26,8'hB2,8'h75,8'h8E,8'h66,
                    8'hCF,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_IGNORED},
    '{4'd0, 4'd4,  {8'h2E,8'h52,8'h4D,8'h46,8'h00,8'h00,
                    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, FT_IGNORED}
  };

endpackage

`default_nettype wire

// File: hw/rtl/fsc_in_if.sv
// Input channel of the file signature classifier: at most one buffer byte per item.
// No dependencies.
`default_nettype none

interface fsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output has_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fsc_out_if.sv
// Output channel of the file signature classifier: one classification per item.
// Depends on fsc_pkg.
`default_nettype none

interface fsc_out_if;
  import fsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] file_type;
  logic [ROW_W-1:0]  matched_row;

  modport source (output valid, output file_type, output matched_row, input ready);
  modport sink   (input valid, input file_type, input matched_row, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fsc_capture.sv
// Input register, header byte store and saturating byte count.
// Depends on fsc_pkg and fsc_in_if.
`default_nettype none

module fsc_capture #(
  parameter int unsigned HeaderWindow = fsc_pkg::DEF_HEADER_WINDOW,
  parameter int unsigned CountW       = $clog2(HeaderWindow + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  fsc_in_if.sink                   in_i,
  input  wire logic                adv_i,
  output fsc_pkg::cap_stat_t       stat_o,
  output fsc_pkg::sig_win_t        win_o,
  output logic [CountW-1:0]        count_o
);
  import fsc_pkg::*;

  localparam int unsigned IdxW = $clog2(HeaderWindow);

  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic              s1_has_q;
  logic              s1_last_q;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        store_q [HeaderWindow];
  logic              room;

  assign in_i.ready = !s1_valid_q || adv_i;

  assign stat_o.valid = s1_valid_q;
  assign stat_o.last  = s1_last_q;

  assign room = s1_has_q && (count_q < CountW'(HeaderWindow));

  // Count including the held item's byte
  always_comb begin
    count_o = count_q;
    if (room) begin
      count_o = count_q + CountW'(1);
    end
  end

  // Window as the compare sees it: the held byte overlays its slot
  always_comb begin
    for (int i = 0; i < SIG_SPAN; i++) begin
      win_o[i] = store_q[i];
      if (room && (count_q == CountW'(i))) begin
        win_o[i] = s1_byte_q;
      end
    end
  end

  // Restart the count after a classification
  always_comb begin
    count_d = count_q;
    if (adv_i) begin
      count_d = s1_last_q ? '0 : count_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      count_q    <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_has_q  <= in_i.has_byte;
      s1_last_q <= in_i.last_byte;
    end
    if (adv_i && room) begin
      store_q[count_q[IdxW-1:0]] <= s1_byte_q;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fsc_match.sv
// Parallel compare of the header window against every signature row, first hit wins.
// Depends on fsc_pkg.
`default_nettype none

module fsc_match #(
  parameter int unsigned CountW = $clog2(fsc_pkg::DEF_HEADER_WINDOW + 1)
) (
  input  fsc_pkg::sig_win_t            win_i,
  input  wire logic [CountW-1:0]       count_i,
  output logic [fsc_pkg::TYPE_W-1:0]   file_type_o,
  output logic [fsc_pkg::ROW_W-1:0]    matched_row_o
);
  import fsc_pkg::*;

  logic [ROW_COUNT-1:0] hit;

  function automatic logic row_hit(sig_row_t r, sig_win_t w, logic [CountW-1:0] c);
    logic                 ok;
    int unsigned          pos_full;
    logic [SIG_IDX_W-1:0] pos;
    ok = (int'(r.offset) + int'(r.length) <= int'(c)) &&
         (int'(r.offset) + int'(r.length) <= int'(SIG_SPAN));
    for (int k = 0; k < SIG_SPAN; k++) begin
      pos_full = int'(r.offset) + k;
      pos      = SIG_IDX_W'(pos_full);
      if ((k < int'(r.length)) && (pos_full < SIG_SPAN)) begin
        if (w[pos] != r.bytes[k]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  always_comb begin
    for (int r = 0; r < ROW_COUNT; r++) begin
      hit[r] = row_hit(SIG_TABLE[r], win_i, count_i);
    end
  end

  // Walk from the lowest priority upwards so the first row overrides
  always_comb begin
    file_type_o   = FT_UNKNOWN;
    matched_row_o = NO_ROW;
    for (int r = ROW_COUNT - 1; r >= 0; r--) begin
      if (hit[r]) begin
        file_type_o   = SIG_TABLE[r].ftype;
        matched_row_o = ROW_W'(r);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/file_signature_classifier.sv
// Path: a last item waits in the input register until the result register is free, then
//   loads its classification there; only an output stall holds it back.
// Throughput: one item per cycle; plain bytes always move on, while a last item waits in
//   the input register until the result register is free, which then stalls the input.
// Reset (rst_ni low, asynchronous) empties both registers and clears the byte count;
//   the header byte store holds no reset value and is only read where it was written.
`default_nettype none

module file_signature_classifier #(
  parameter int unsigned HeaderWindow = fsc_pkg::DEF_HEADER_WINDOW
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fsc_in_if.sink    in_i,
  fsc_out_if.source out_o
);
  import fsc_pkg::*;

  localparam int unsigned CountW = $clog2(HeaderWindow + 1);

  cap_stat_t         cap_stat;
  sig_win_t          win;
  logic [CountW-1:0] count;
  logic              res_free;
  logic              adv;
  logic [TYPE_W-1:0] type_d;
  logic [ROW_W-1:0]  row_d;

  logic              res_valid_q;
  logic [TYPE_W-1:0] res_type_q;
  logic [ROW_W-1:0]  res_row_q;

  // Result register can take a new item when empty or being drained
  assign res_free = !res_valid_q || out_o.ready;

  // Advance the held item: plain bytes always move on, a last item needs the result slot
  assign adv = cap_stat.valid && (!cap_stat.last || res_free);

  fsc_capture #(
    .HeaderWindow (HeaderWindow),
    .CountW       (CountW)
  ) u_capture (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .stat_o  (cap_stat),
    .win_o   (win),
    .count_o (count)
  );

  fsc_match #(
    .CountW (CountW)
  ) u_match (
    .win_i         (win),
    .count_i       (count),
    .file_type_o   (type_d),
    .matched_row_o (row_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      if (adv && cap_stat.last) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Load the classification of a finished buffer
  always_ff @(posedge clk_i) begin
    if (adv && cap_stat.last) begin
      res_type_q <= type_d;
      res_row_q  <= row_d;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.file_type   = res_type_q;
  assign out_o.matched_row = res_row_q;

endmodule

`default_nettype wire

// File: hw/rtl/fsc_checker.sv
// Port-level checks of the file signature classifier and the bind that attaches them.
// Depends on fsc_pkg and on the top level's interface ports.
`default_nettype none

module fsc_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [fsc_pkg::TYPE_W-1:0] file_type_i,
  input wire logic [fsc_pkg::ROW_W-1:0]  matched_row_i
);
  import fsc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(file_type_i) && $stable(matched_row_i))
    else $error("result changed while stalled");

  // Unknown type goes with the no-match row and only with it
  a_unknown_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((file_type_i == FT_UNKNOWN) == (matched_row_i == NO_ROW)))
    else $error("type and row disagree on a miss");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (matched_row_i < ROW_W'(ROW_COUNT)) || (matched_row_i == NO_ROW))
    else $error("row outside the table");

endmodule

bind file_signature_classifier fsc_checker u_fsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .file_type_i   (out_o.file_type),
  .matched_row_i (out_o.matched_row)
);

`default_nettype wire
